/* src/sha256_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared constants, round tables, the round-unit control bundle and the
// SHA-256 mixing functions used by the byte-stream hash core.
// ----------------------------------------------------------------------------
package sha256_pkg;

  // Block geometry and padding positions.
  localparam logic [5:0] FILL_LAST   = 6'd63;
  localparam logic [5:0] LEN_POS     = 6'd56;
  localparam logic [7:0] PAD_MARK    = 8'h80;
  localparam logic [5:0] LOAD_LAST   = 6'd16;
  localparam logic [5:0] ROUND_LAST  = 6'd63;
  localparam logic [5:0] WBACK_LAST  = 6'd8;
  localparam logic [5:0] CHAIN_WORDS = 6'd8;
  localparam logic [2:0] DIGEST_LAST = 3'd7;

  // Round constants, one per round.
  localparam logic [31:0] K_TABLE [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  // Initial hash value of every message.
  localparam logic [31:0] IV_TABLE [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  // Control bundle from the sequencer to the round unit.
  typedef struct packed {
    logic       w_load;    // shift a block word into the schedule
    logic       v_load;    // load one working variable from the chain
    logic [2:0] v_idx;     // working variable selected for load or readout
    logic       round_en;  // run one compression round
    logic [5:0] round;     // current round number
  } rnd_ctrl_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] ch_fn(input logic [31:0] x, input logic [31:0] y,
                                        input logic [31:0] z);
    return (x & y) ^ (~x & z);
  endfunction

  function automatic logic [31:0] maj_fn(input logic [31:0] x, input logic [31:0] y,
                                         input logic [31:0] z);
    return (x & y) ^ (x & z) ^ (y & z);
  endfunction

endpackage

/* src/sha256_buf_mem.sv */
// ----------------------------------------------------------------------------
// SHA-256 block buffer memory
// Sixteen 32-bit words written one byte at a time, big-endian within a word,
// and read one whole word per cycle with registered read data.
// ----------------------------------------------------------------------------
module sha256_buf_mem
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        wr_en,
  input  logic [5:0]  wr_addr,
  input  logic [7:0]  wr_byte,
  input  logic        rd_en,
  input  logic [3:0]  rd_addr,
  output logic [31:0] rd_data
);

  logic [3:0][7:0] mem [16];
  logic [31:0]     rd_data_r;
  logic [1:0]      wr_lane;

  // Byte 0 of a word is its most significant byte.
  assign wr_lane = 2'd3 - wr_addr[1:0];

  // Byte write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[5:2]][wr_lane] <= wr_byte;
    end
  end

  // Word read port with registered read data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* src/sha256_chain_mem.sv */
// ----------------------------------------------------------------------------
// SHA-256 chaining value memory
// Eight 32-bit chaining words with a registered read port and a write port.
// A single flag marks the whole memory as holding the initial hash value, so
// a new message needs no write sweep.
// ----------------------------------------------------------------------------
module sha256_chain_mem
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        rd_en,
  input  logic [2:0]  rd_addr,
  output logic [31:0] rd_data,
  input  logic        wr_en,
  input  logic [2:0]  wr_addr,
  input  logic [31:0] wr_data,
  input  logic        init,
  input  logic        commit
);

  logic [31:0] mem [8];
  logic [31:0] mem_q_r;
  logic [2:0]  idx_q_r;
  logic        iv_q_r;
  logic        iv_r;
  logic        iv_nxt;

  // The initial value flag is set for a new message and cleared once the
  // first compression has written all eight words back.
  always_comb begin
    iv_nxt = iv_r;
    if (init) begin
      iv_nxt = 1'b1;
    end else if (commit) begin
      iv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b1;
    end else begin
      iv_r <= iv_nxt;
    end
  end

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the flag is sampled with the read so the overlay matches it.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
      idx_q_r <= rd_addr;
      iv_q_r  <= iv_r;
    end
  end

  assign rd_data = iv_q_r ? IV_TABLE[idx_q_r] : mem_q_r;

endmodule

/* src/sha256_rounds.sv */
// ----------------------------------------------------------------------------
// SHA-256 round unit
// Holds the 16-word message schedule window and the eight working variables,
// and runs one compression round per cycle while ctrl.round_en is set.
// ----------------------------------------------------------------------------
module sha256_rounds
  import sha256_pkg::*;
(
  input  logic        clk,
  input  rnd_ctrl_t   ctrl,
  input  logic [31:0] w_in,
  input  logic [31:0] v_in,
  output logic [31:0] v_out
);

  logic [31:0] w_r [16];
  logic [31:0] v_r [8];
  logic [31:0] w_new;
  logic [31:0] w_src;
  logic [31:0] t1;
  logic [31:0] t2;

  // Schedule expansion and round sums.
  always_comb begin
    w_new = w_r[0] + ssig0(w_r[1]) + w_r[9] + ssig1(w_r[14]);
    t1    = v_r[7] + bsig1(v_r[4]) + ch_fn(v_r[4], v_r[5], v_r[6])
          + K_TABLE[ctrl.round] + w_r[0];
    t2    = bsig0(v_r[0]) + maj_fn(v_r[0], v_r[1], v_r[2]);
    w_src = ctrl.w_load ? w_in : w_new;
  end

  // Schedule window: the oldest word sits at index 0.
  always_ff @(posedge clk) begin
    if (ctrl.w_load || ctrl.round_en) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i + 1];
      end
      w_r[15] <= w_src;
    end
  end

  // Working variables.
  always_ff @(posedge clk) begin
    if (ctrl.v_load) begin
      v_r[ctrl.v_idx] <= v_in;
    end else if (ctrl.round_en) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  assign v_out = v_r[ctrl.v_idx];

endmodule

/* src/sha256_byte_stream_hash_core.sv */
// ----------------------------------------------------------------------------
// SHA-256 byte-stream hash core
// Absorbs one message byte per transfer and returns the eight digest words
// after a finish transfer.
// ----------------------------------------------------------------------------
// A data byte is taken while the core is idle and the 64-byte buffer is not yet full.
// The byte that fills a block starts a compression (loading the block and
// chaining words from their memories, the 64 rounds of the single round
// unit, then adding the result back into the chaining memory), during
// which in_ready is low. A finish transfer writes the padding one byte per
// cycle (64 minus the fill level, and 64 more ahead of a second block),
// compresses one block, or two when fewer than nine bytes of the block are
// left, and then sends the eight digest words, each read in ST_OUT_RD and
// registered in ST_OUT_LD, word 0 first, the last with out_last_word set.
// The next message can start while the final word still waits on out_ready.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hash_core
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_PAD    = 7'b0000010,
    ST_LOAD   = 7'b0000100,
    ST_ROUND  = 7'b0001000,
    ST_WBACK  = 7'b0010000,
    ST_OUT_RD = 7'b0100000,
    ST_OUT_LD = 7'b1000000
  } state_t;

  // Control registers.
  state_t      state_r,    state_nxt;
  logic [5:0]  cnt_r,      cnt_nxt;
  logic [5:0]  fill_r,     fill_nxt;
  logic [63:0] msg_cnt_r,  msg_cnt_nxt;
  logic        pad_mode_r, pad_mode_nxt;
  logic        first_r,    first_nxt;
  logic        two_blk_r,  two_blk_nxt;
  logic [2:0]  out_idx_r,  out_idx_nxt;
  logic        out_valid_r, out_valid_nxt;

  // Payload registers.
  logic [63:0] bit_len_r;
  logic [31:0] out_word_r;
  logic [2:0]  out_index_r;
  logic        out_last_r;

  // Memory and round unit hookups.
  logic        buf_wr_en;
  logic [7:0]  buf_wr_byte;
  logic        buf_rd_en;
  logic [31:0] buf_rd_data;
  logic        chain_rd_en;
  logic [2:0]  chain_rd_addr;
  logic [31:0] chain_rd_data;
  logic        chain_wr_en;
  logic        chain_init;
  logic        chain_commit;
  logic [31:0] v_out;
  rnd_ctrl_t   rnd_ctrl;

  logic        in_fire;
  logic        out_load;
  logic [2:0]  lag_idx;
  logic [7:0]  len_byte;
  logic [7:0]  pad_byte;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  // Index of the word whose read data lands this cycle.
  assign lag_idx = 3'(cnt_r - 6'd1);

  // Padding byte: the marker first, then zeros, then the big-endian length
  // in the last eight bytes of the final block.
  assign len_byte = bit_len_r[{3'd7 - fill_r[2:0], 3'b000} +: 8];
  always_comb begin
    if (first_r) begin
      pad_byte = PAD_MARK;
    end else if (!two_blk_r && (fill_r >= LEN_POS)) begin
      pad_byte = len_byte;
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign buf_wr_byte = (state_r == ST_PAD) ? pad_byte : in_data_byte;

  // Sequencer.
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    fill_nxt     = fill_r;
    msg_cnt_nxt  = msg_cnt_r;
    pad_mode_nxt = pad_mode_r;
    first_nxt    = first_r;
    two_blk_nxt  = two_blk_r;
    out_idx_nxt  = out_idx_r;
    buf_wr_en    = 1'b0;
    buf_rd_en    = 1'b0;
    chain_rd_en  = 1'b0;
    chain_rd_addr = cnt_r[2:0];
    chain_wr_en  = 1'b0;
    chain_init   = 1'b0;
    chain_commit = 1'b0;
    out_load     = 1'b0;
    rnd_ctrl     = '0;
    rnd_ctrl.v_idx = lag_idx;
    rnd_ctrl.round = cnt_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (!in_kind) begin
            buf_wr_en   = 1'b1;
            msg_cnt_nxt = msg_cnt_r + 64'd1;
            if (fill_r == FILL_LAST) begin
              fill_nxt  = '0;
              cnt_nxt   = '0;
              state_nxt = ST_LOAD;
            end else begin
              fill_nxt = fill_r + 6'd1;
            end
          end else begin
            pad_mode_nxt = 1'b1;
            first_nxt    = 1'b1;
            two_blk_nxt  = (fill_r >= LEN_POS);
            state_nxt    = ST_PAD;
          end
        end
      end

      ST_PAD: begin
        buf_wr_en = 1'b1;
        first_nxt = 1'b0;
        if (fill_r == FILL_LAST) begin
          fill_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = ST_LOAD;
        end else begin
          fill_nxt = fill_r + 6'd1;
        end
      end

      // Read block words and chaining words; each lands in the next cycle.
      ST_LOAD: begin
        buf_rd_en   = (cnt_r < LOAD_LAST);
        chain_rd_en = (cnt_r < CHAIN_WORDS);
        rnd_ctrl.w_load = (cnt_r != 6'd0);
        rnd_ctrl.v_load = (cnt_r != 6'd0) && (cnt_r <= CHAIN_WORDS);
        if (cnt_r == LOAD_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_ROUND;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end

      ST_ROUND: begin
        rnd_ctrl.round_en = 1'b1;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == ROUND_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_WBACK;
        end
      end

      // Read each chaining word and write back its sum with the round result.
      ST_WBACK: begin
        chain_rd_en = (cnt_r < CHAIN_WORDS);
        chain_wr_en = (cnt_r != 6'd0);
        if (cnt_r == WBACK_LAST) begin
          chain_commit = 1'b1;
          cnt_nxt      = '0;
          if (!pad_mode_r) begin
            state_nxt = ST_IDLE;
          end else if (two_blk_r) begin
            two_blk_nxt = 1'b0;
            state_nxt   = ST_PAD;
          end else begin
            out_idx_nxt = '0;
            state_nxt   = ST_OUT_RD;
          end
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end

      // Read the next digest word once the output register will be free.
      ST_OUT_RD: begin
        chain_rd_addr = out_idx_r;
        if (!out_valid_r || out_ready) begin
          chain_rd_en = 1'b1;
          state_nxt   = ST_OUT_LD;
        end
      end

      ST_OUT_LD: begin
        out_load = 1'b1;
        if (out_idx_r == DIGEST_LAST) begin
          chain_init   = 1'b1;
          msg_cnt_nxt  = '0;
          pad_mode_nxt = 1'b0;
          state_nxt    = ST_IDLE;
        end else begin
          out_idx_nxt = out_idx_r + 3'd1;
          state_nxt   = ST_OUT_RD;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register valid.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      fill_r      <= '0;
      msg_cnt_r   <= '0;
      pad_mode_r  <= 1'b0;
      first_r     <= 1'b0;
      two_blk_r   <= 1'b0;
      out_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      fill_r      <= fill_nxt;
      msg_cnt_r   <= msg_cnt_nxt;
      pad_mode_r  <= pad_mode_nxt;
      first_r     <= first_nxt;
      two_blk_r   <= two_blk_nxt;
      out_idx_r   <= out_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Message length in bits, captured on the finish transfer.
  always_ff @(posedge clk) begin
    if (in_fire && in_kind) begin
      bit_len_r <= {msg_cnt_r[60:0], 3'b000};
    end
  end

  // Digest word output register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word_r  <= chain_rd_data;
      out_index_r <= out_idx_r;
      out_last_r  <= (out_idx_r == DIGEST_LAST);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_digest_word = out_word_r;
  assign out_word_index  = out_index_r;
  assign out_last_word   = out_last_r;

  sha256_buf_mem u_buf (
    .clk     (clk),
    .wr_en   (buf_wr_en),
    .wr_addr (fill_r),
    .wr_byte (buf_wr_byte),
    .rd_en   (buf_rd_en),
    .rd_addr (cnt_r[3:0]),
    .rd_data (buf_rd_data)
  );

  sha256_chain_mem u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (chain_rd_en),
    .rd_addr (chain_rd_addr),
    .rd_data (chain_rd_data),
    .wr_en   (chain_wr_en),
    .wr_addr (lag_idx),
    .wr_data (chain_rd_data + v_out),
    .init    (chain_init),
    .commit  (chain_commit)
  );

  sha256_rounds u_rounds (
    .clk   (clk),
    .ctrl  (rnd_ctrl),
    .w_in  (buf_rd_data),
    .v_in  (chain_rd_data),
    .v_out (v_out)
  );

endmodule

/* src/sha256_checker.sv */
// ----------------------------------------------------------------------------
// SHA-256 core port checker
// Watches the ports of the hash core for digest ordering, stall behavior and
// the interlock between digest output and new input.
// ----------------------------------------------------------------------------
module sha256_checker
  import sha256_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_digest_word,
  input logic [2:0]  out_word_index,
  input logic        out_last_word
);

  logic [2:0] exp_idx_r;

  // Expected index of the next digest word transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_idx_r <= '0;
    end else if (out_valid && out_ready) begin
      exp_idx_r <= out_word_index + 3'd1;
    end
  end

  // Digest words come out in order, starting at word 0.
  a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word_index == exp_idx_r))
    else $error("digest word out of order");

  // The last marker sits on word 7 and only there.
  a_last_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == DIGEST_LAST)))
    else $error("last marker on wrong digest word");

  // No new input is taken while a digest is only partly delivered.
  a_no_input_mid_digest: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_word) |-> !in_ready)
    else $error("input accepted in the middle of a digest");

  // A stalled digest word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_digest_word)))
    else $error("stalled digest word changed");

endmodule

bind sha256_byte_stream_hash_core sha256_checker u_sha256_checker (.*);

/* tb/sv/sha256_byte_stream_hash_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 byte-stream hash core testbench
// Streams byte messages and finish transfers into the core, predicts the
// digest of every message with its own SHA-256 model and checks each digest
// word transfer in order against it, under random idling on both channels.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hash_core_test;

  // Kind codes of an input transfer.
  localparam logic KIND_ABSORB = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  // Byte patterns of generated messages.
  localparam int PAT_RANDOM = 0;
  localparam int PAT_ZEROS  = 1;
  localparam int PAT_ONES   = 2;

  // Run shape.
  localparam int ITEM_TARGET  = 460;
  localparam int IDLE_PCT     = 28;
  localparam int HOLD_AT      = 120;
  localparam int HOLD_LEN     = 1500;
  localparam int CALM_IN_LO   = 200;
  localparam int CALM_IN_HI   = 300;
  localparam int CALM_OUT_LO  = 40;
  localparam int CALM_OUT_HI  = 100;
  localparam int DRAIN_AT     = 330;
  localparam int SETTLE_LEN   = 400;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct {
    logic       kind;
    logic [7:0] data;
    bit         drain;
  } byte_op_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  // SHA-256 round constants and initial hash value.
  localparam logic [31:0] ROUND_K [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };
  localparam logic [31:0] START_HASH [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_kind = KIND_ABSORB;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  // Stimulus and expectations.
  byte_op_t     pending_ops[$];
  digest_word_t digest_words_due[$];
  int           ops_queued = 0;
  int           items_taken = 0;
  int           words_predicted = 0;
  int           words_seen = 0;
  int           mismatches = 0;
  int           cycle_count = 0;
  int           hold_left = 0;
  bit           hold_used = 1'b0;

  // Predictor state.
  logic [31:0] hash_state [8];
  logic [7:0]  block_bytes [64];
  int          block_fill;
  logic [63:0] msg_length;

  sha256_byte_stream_hash_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    logic [63:0] twice;
    twice = {x, x};
    return 32'(twice >> n);
  endfunction

  // Start a new message: initial hash, empty block, zero length.
  function automatic void restart_hash();
    for (int i = 0; i < 8; i++) hash_state[i] = START_HASH[i];
    block_fill = 0;
    msg_length = 64'd0;
  endfunction

  // Run the 64 rounds over the block and add the result into the hash.
  function automatic void compress_block_bytes();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1;
    logic [31:0] t2;
    for (int r = 0; r < 16; r++) begin
      w[r] = {block_bytes[4*r], block_bytes[4*r+1], block_bytes[4*r+2], block_bytes[4*r+3]};
    end
    for (int r = 16; r < 64; r++) begin
      w[r] = w[r-16] + w[r-7]
           + (ror32(w[r-15], 7) ^ ror32(w[r-15], 18) ^ (w[r-15] >> 3))
           + (ror32(w[r-2], 17) ^ ror32(w[r-2], 19) ^ (w[r-2] >> 10));
    end
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + w[r];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int i = 7; i > 0; i--) v[i] = v[i-1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
  endfunction

  // Apply one accepted transfer; a finish queues the eight digest words.
  function automatic void hash_transfer(input logic kind, input logic [7:0] data);
    logic [63:0]  bit_len;
    int           pos;
    digest_word_t dw;
    if (kind == KIND_ABSORB) begin
      block_bytes[block_fill] = data;
      msg_length = msg_length + 64'd1;
      block_fill = block_fill + 1;
      if (block_fill == 64) begin
        compress_block_bytes();
        block_fill = 0;
      end
      return;
    end
    bit_len = msg_length << 3;
    pos = block_fill;
    block_bytes[pos] = 8'h80;
    pos = pos + 1;
    // Too little room for the length: the padding spills into a second block.
    if (pos > 56) begin
      while (pos < 64) begin
        block_bytes[pos] = 8'h00;
        pos = pos + 1;
      end
      compress_block_bytes();
      pos = 0;
    end
    while (pos < 56) begin
      block_bytes[pos] = 8'h00;
      pos = pos + 1;
    end
    for (int i = 0; i < 8; i++) block_bytes[56+i] = bit_len[63-8*i -: 8];
    compress_block_bytes();
    for (int i = 0; i < 8; i++) begin
      dw.word = hash_state[i];
      dw.idx  = 3'(i);
      dw.last = (i == 7);
      digest_words_due.push_back(dw);
    end
    restart_hash();
  endfunction

  function automatic void push_op(input logic kind, input logic [7:0] data, input bit drain);
    byte_op_t op;
    op.kind  = kind;
    op.data  = data;
    op.drain = drain;
    pending_ops.push_back(op);
    ops_queued = ops_queued + 1;
  endfunction

  // Queue a whole message and its finish transfer.
  function automatic void push_message(input int len, input int pattern, input bit drain);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case (pattern)
        PAT_ZEROS: b = 8'h00;
        PAT_ONES:  b = 8'hFF;
        default:   b = 8'($urandom_range(255));
      endcase
      push_op(KIND_ABSORB, b, drain && (i == 0));
    end
    push_op(KIND_FINISH, 8'($urandom_range(255)), drain && (len == 0));
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at word %0d: %s got %h expected %h", words_seen, what, got, want);
    mismatches = mismatches + 1;
  endtask

  // Driver: present the next pending transfer and predict each accepted one.
  always @(posedge clk) begin : drive
    byte_op_t nxt;
    bit       send;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        hash_transfer(in_kind, in_data_byte);
        if (in_kind == KIND_FINISH) words_predicted = words_predicted + 8;
        items_taken <= items_taken + 1;
      end
      if (!in_valid || in_ready) begin
        send = (pending_ops.size() > 0) &&
               ((items_taken >= CALM_IN_LO && items_taken < CALM_IN_HI) ||
                ($urandom_range(99) >= IDLE_PCT));
        // A drain-marked transfer waits until every digest word has come back.
        if (send && pending_ops[0].drain && (words_seen != words_predicted)) send = 1'b0;
        if (send) begin
          nxt = pending_ops.pop_front();
          in_valid     <= 1'b1;
          in_kind      <= nxt.kind;
          in_data_byte <= nxt.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each digest word transfer and pace out_ready.
  always @(posedge clk) begin : watch
    digest_word_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (digest_words_due.size() == 0) begin
          report_mismatch("unexpected word", out_digest_word, 32'd0);
        end else begin
          want = digest_words_due.pop_front();
          if (out_digest_word !== want.word)
            report_mismatch("digest_word", out_digest_word, want.word);
          if (out_word_index !== want.idx)
            report_mismatch("word_index", 32'(out_word_index), 32'(want.idx));
          if (out_last_word !== want.last)
            report_mismatch("last_word", 32'(out_last_word), 32'(want.last));
          words_seen <= words_seen + 1;
        end
      end
      // One long hold-off lets the core fill up and stall its input.
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!hold_used && items_taken >= HOLD_AT) begin
        hold_used <= 1'b1;
        hold_left <= HOLD_LEN;
        out_ready <= 1'b0;
      end else if (words_seen >= CALM_OUT_LO && words_seen < CALM_OUT_HI) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[sha256_byte_stream_hash_core] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int len;
    int pick;
    int pattern;
    restart_hash();
    for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;

    // Directed: empty messages back to back, "abc", single extreme bytes,
    // and finish transfers carrying nonzero data bytes that must be ignored.
    push_op(KIND_FINISH, 8'h00, 1'b0);
    push_op(KIND_FINISH, 8'hFF, 1'b0);
    push_op(KIND_ABSORB, 8'h61, 1'b0);
    push_op(KIND_ABSORB, 8'h62, 1'b0);
    push_op(KIND_ABSORB, 8'h63, 1'b0);
    push_op(KIND_FINISH, 8'hA5, 1'b0);
    push_op(KIND_ABSORB, 8'h00, 1'b0);
    push_op(KIND_FINISH, 8'h00, 1'b0);
    push_op(KIND_ABSORB, 8'hFF, 1'b0);
    push_op(KIND_FINISH, 8'hFF, 1'b0);
    push_op(KIND_ABSORB, 8'h55, 1'b0);
    push_op(KIND_ABSORB, 8'hAA, 1'b0);
    push_op(KIND_FINISH, 8'h5A, 1'b0);

    // Random messages, with lengths around the padding and block edges.
    while (ops_queued < ITEM_TARGET) begin
      pick = $urandom_range(9);
      if (pick <= 4) len = $urandom_range(20);
      else if (pick == 5) len = 0;
      else if (pick == 6) begin
        case ($urandom_range(7))
          0: len = 55;
          1: len = 56;
          2: len = 57;
          3: len = 63;
          4: len = 64;
          5: len = 65;
          6: len = 119;
          default: len = 120;
        endcase
      end else if (pick <= 8) len = $urandom_range(70, 21);
      else len = $urandom_range(140, 100);
      // The last message is cut short so the run stays near its item count.
      if (len > ITEM_TARGET - ops_queued - 1) len = ITEM_TARGET - ops_queued - 1;
      pattern = ($urandom_range(9) == 0) ? PAT_ZEROS :
                ($urandom_range(9) == 0) ? PAT_ONES : PAT_RANDOM;
      push_message(len, pattern, (ops_queued < DRAIN_AT) &&
                                 (ops_queued + len + 1 >= DRAIN_AT));
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every transfer and every digest word, then let the core settle.
    @(negedge clk);
    while (pending_ops.size() != 0 || in_valid || words_seen != words_predicted)
      @(negedge clk);
    repeat (SETTLE_LEN) @(posedge clk);
    if (mismatches == 0) begin
      $display("[sha256_byte_stream_hash_core] OK");
    end else begin
      $display("[sha256_byte_stream_hash_core] ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
src/sha256_pkg.sv
src/sha256_buf_mem.sv
src/sha256_chain_mem.sv
src/sha256_rounds.sv
src/sha256_byte_stream_hash_core.sv
src/sha256_checker.sv
tb/sv/sha256_byte_stream_hash_core_test.sv
